// ===== hdl/dmsc_pkg.sv =====
// shared constants and types for the mhc 5x5 demosaic
// no dependencies; imported by every module of the block but dmsc_ram
`timescale 1ns / 1ps
`default_nettype none

package dmsc_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int DIM_W     = 12;
    localparam int ROW_W     = 12;
    localparam int PIX_W     = 8;

    localparam int NUM_BANKS = 4;
    localparam int BANK_W    = 2;

    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = QPTR_W + 1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(424);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(636);
    localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(4);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // window update codes
    localparam logic [1:0] WOP_LOAD      = 2'd0;
    localparam logic [1:0] WOP_SHIFT_NEW = 2'd1;
    localparam logic [1:0] WOP_SHIFT_REP = 2'd2;

    // column source: line store bank 0..3 or the incoming sample
    localparam logic [2:0] SEL_BYPASS = 3'd4;

    typedef logic [4:0][PIX_W-1:0] column_t;

    typedef struct packed {
        logic       do_edge;
        logic       edge_slot;
        logic       do_win;
        logic [1:0] win_op;
        logic       row_odd;
        logic       col_odd;
        logic       frame_end;
    } qctrl_t;

    typedef struct packed {
        qctrl_t  ctrl;
        column_t column;
    } qentry_t;

endpackage

`default_nettype wire

// ===== hdl/bayer_demosaic_mhc_5x5.sv =====
// top level: malvar-he-cutler 5x5 demosaic of an rggb raster, apb registers
// path: the completing beat is registered in p1, then the queue, then the output;
// results trail the input by two rows plus two pixels, drain beats flush the tail
// throughput: one beat per cycle if the queue has room, set by one line store read
// reset: synchronous active-low, clears positions, queue and output valid; registers
// return to width 424 and height 636; line store and window hold no reset value
`timescale 1ns / 1ps
`default_nettype none

module bayer_demosaic_mhc_5x5 import dmsc_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [PIX_W-1:0]    s_tdata,   // raw_pixel
    input  wire logic                s_tuser,   // kind
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [3*PIX_W-1:0]       m_tdata,   // red, green, blue
    output logic                     m_tlast,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [DIM_W-1:0]  width_reg, height_reg, width_eff, height_eff;
    logic              cfg_wr;
    logic              push, pop;
    qentry_t           push_entry, head;
    logic [QCNT_W-1:0] q_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HEIGHT) ? {20'b0, height_reg} : {20'b0, width_reg};

    always_comb begin
        if (width_reg < MIN_DIM) begin
            width_eff = MIN_DIM;
        end else if (width_reg > DIM_W'(MAX_WIDTH)) begin
            width_eff = DIM_W'(MAX_WIDTH);
        end else begin
            width_eff = width_reg;
        end
        height_eff = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) begin
                width_reg <= pwdata[DIM_W-1:0];
            end else begin
                height_reg <= pwdata[DIM_W-1:0];
            end
        end
    end

    dmsc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .cfg_clear  (cfg_wr),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .q_count    (q_count),
        .push       (push),
        .push_entry (push_entry)
    );

    dmsc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .count      (q_count)
    );

    dmsc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .q_nonempty (q_count != '0),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// ===== hdl/dmsc_ram.sv =====
// generic single write port ram with registered read-first read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dmsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/dmsc_front.sv =====
// front end: accepts beats, tracks raster positions, owns the line store
// banks and assembles one 5-tall column per beat; depends on dmsc_pkg, dmsc_ram
`timescale 1ns / 1ps
`default_nettype none

module dmsc_front import dmsc_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [DIM_W-1:0]  width_eff,
    input  wire logic [DIM_W-1:0]  height_eff,
    input  wire logic              cfg_clear,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              s_tuser,
    input  wire logic [PIX_W-1:0]  s_tdata,
    input  wire logic [QCNT_W-1:0] q_count,
    output logic                   push,
    output qentry_t                push_entry
);

    logic [COL_W-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;

    logic              live, accept, ign, idle_clr, work, started, near_ok;
    logic              edge_hit, frame_end, st_we;
    logic [DIM_W-1:0]  col_ext, vc;
    logic [ROW_W:0]    vr, rc;
    logic [2:0]        sel [5];
    logic signed [ROW_W+2:0] ys [5];
    qctrl_t            ctrl;

    logic              p1_valid_reg;
    qctrl_t            p1_ctrl_reg;
    logic [2:0]        p1_sel_reg [5];
    logic [PIX_W-1:0]  p1_pix_reg;
    logic [PIX_W-1:0]  bank_q [NUM_BANKS];

    assign s_tready = (q_count + QCNT_W'(p1_valid_reg)) < QCNT_W'(QDEPTH);

    always_comb begin
        live     = in_row_reg < height_eff;
        accept   = s_tvalid && s_tready;
        ign      = live && s_tuser;
        idle_clr = !live && (out_row_reg >= height_eff);
        work     = accept && !ign && !idle_clr;
        col_ext  = DIM_W'(out_col_reg);
        near_ok  = (col_ext + DIM_W'(3)) <= width_eff;

        if (live) begin
            vr      = {1'b0, in_row_reg};
            vc      = DIM_W'(in_col_reg);
            started = (in_row_reg > ROW_W'(2)) ||
                      ((in_row_reg == ROW_W'(2)) && (in_col_reg >= COL_W'(2)));
        end else begin
            started = 1'b1;
            if (near_ok) begin
                vr = {1'b0, out_row_reg} + (ROW_W+1)'(2);
                vc = col_ext + DIM_W'(2);
            end else begin
                vr = {1'b0, out_row_reg} + (ROW_W+1)'(3);
                vc = col_ext - (width_eff - DIM_W'(2));
            end
        end

        rc        = vr - (ROW_W+1)'(2);
        edge_hit  = (vc < DIM_W'(2)) && (vr >= (ROW_W+1)'(2)) && (rc < {1'b0, height_eff});
        frame_end = (out_row_reg == (height_eff - DIM_W'(1))) &&
                    (col_ext == (width_eff - DIM_W'(1)));

        for (int k = 0; k < 5; k++) begin
            ys[k] = $signed({2'b00, rc}) + (ROW_W+3)'(k) - (ROW_W+3)'(2);
            if (ys[k] < 0) begin
                ys[k] = ys[k] + (ROW_W+3)'(2);
            end
            if (ys[k] >= $signed({3'b000, height_eff})) begin
                ys[k] = ys[k] - (ROW_W+3)'(2);
            end
            if (ys[k] < 0) begin
                ys[k] = '0;
            end
            if (live && (ys[k][ROW_W-1:0] == in_row_reg)) begin
                sel[k] = SEL_BYPASS;
            end else begin
                sel[k] = {1'b0, ys[k][BANK_W-1:0]};
            end
        end

        ctrl.do_edge   = edge_hit;
        ctrl.edge_slot = vc[0];
        ctrl.do_win    = started;
        ctrl.row_odd   = out_row_reg[0];
        ctrl.col_odd   = out_col_reg[0];
        ctrl.frame_end = frame_end;
        if (out_col_reg == '0) begin
            ctrl.win_op = WOP_LOAD;
        end else if (near_ok) begin
            ctrl.win_op = WOP_SHIFT_NEW;
        end else begin
            ctrl.win_op = WOP_SHIFT_REP;
        end

        st_we = work && live && !(started && frame_end);

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_clear) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (accept && !ign) begin
            if (idle_clr || (started && frame_end)) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else begin
                if (started) begin
                    if ((col_ext + DIM_W'(1)) >= width_eff) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end else begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
                if (live) begin
                    if ((DIM_W'(in_col_reg) + DIM_W'(1)) >= width_eff) begin
                        in_col_next = '0;
                        in_row_next = in_row_reg + ROW_W'(1);
                    end else begin
                        in_col_next = in_col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        dmsc_ram #(
            .WIDTH(PIX_W),
            .DEPTH(MAX_WIDTH)
        ) u_bank (
            .clk   (aclk),
            .we    (st_we && (in_row_reg[BANK_W-1:0] == BANK_W'(b))),
            .waddr (in_col_reg),
            .wdata (s_tdata),
            .raddr (vc[COL_W-1:0]),
            .rdata (bank_q[b])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            p1_valid_reg <= work && (edge_hit || started);
        end
    end

    always_ff @(posedge aclk) begin
        p1_ctrl_reg <= ctrl;
        p1_pix_reg  <= s_tdata;
        for (int k = 0; k < 5; k++) begin
            p1_sel_reg[k] <= sel[k];
        end
    end

    always_comb begin
        push            = p1_valid_reg;
        push_entry.ctrl = p1_ctrl_reg;
        for (int k = 0; k < 5; k++) begin
            if (p1_sel_reg[k] == SEL_BYPASS) begin
                push_entry.column[k] = p1_pix_reg;
            end else begin
                push_entry.column[k] = bank_q[p1_sel_reg[k][BANK_W-1:0]];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dmsc_queue.sv =====
// short queue of column beats between front and back end
// depends on dmsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dmsc_queue import dmsc_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire qentry_t           push_entry,
    input  wire logic              pop,
    output qentry_t                head,
    output logic [QCNT_W-1:0]      count
);

    qentry_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dmsc_back.sv =====
// back end: edge columns, 5x5 window, mhc filters and output register
// depends on dmsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dmsc_back import dmsc_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire qentry_t           head,
    input  wire logic              q_nonempty,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [3*PIX_W-1:0]     m_tdata,
    output logic                   m_tlast
);

    column_t                  win_reg  [5];
    column_t                  win_next [5];
    column_t                  edge_reg [2];
    logic                     m_tvalid_reg;
    logic [3*PIX_W-1:0]       m_tdata_reg, m_tdata_next;
    logic                     m_tlast_reg;
    logic signed [14:0]       cc, hn, vn, hf, vf, diag, plus, far, gf, df, hz, vt;
    logic [PIX_W-1:0]         r_v, g_v, b_v, cc_u;

    function automatic logic signed [14:0] ext(input logic [PIX_W-1:0] v);
        return $signed({7'b0, v});
    endfunction

    function automatic logic [PIX_W-1:0] finish(input logic signed [14:0] s);
        logic signed [14:0] t;
        t = s >>> 4;
        if (s < 0) begin
            return '0;
        end else if (t > 15'sd255) begin
            return 8'd255;
        end
        return t[PIX_W-1:0];
    endfunction

    assign pop      = q_nonempty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        case (head.ctrl.win_op)
            WOP_LOAD: begin
                win_next[0] = edge_reg[0];
                win_next[1] = edge_reg[1];
                win_next[2] = edge_reg[0];
                win_next[3] = edge_reg[1];
                win_next[4] = head.column;
            end
            WOP_SHIFT_NEW: begin
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = win_reg[3];
                win_next[3] = win_reg[4];
                win_next[4] = head.column;
            end
            default: begin
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = win_reg[3];
                win_next[3] = win_reg[4];
                win_next[4] = win_reg[3];
            end
        endcase

        cc_u = win_next[2][2];
        cc   = ext(cc_u);
        hn   = ext(win_next[1][2]) + ext(win_next[3][2]);
        vn   = ext(win_next[2][1]) + ext(win_next[2][3]);
        hf   = ext(win_next[0][2]) + ext(win_next[4][2]);
        vf   = ext(win_next[2][0]) + ext(win_next[2][4]);
        diag = ext(win_next[1][1]) + ext(win_next[3][1]) +
               ext(win_next[1][3]) + ext(win_next[3][3]);
        plus = hn + vn;
        far  = hf + vf;
        gf   = (plus <<< 2) - (far <<< 1) + (cc <<< 3);
        df   = (diag <<< 2) - (far + (far <<< 1)) + ((cc <<< 3) + (cc <<< 2));
        hz   = (hn <<< 3) - (hf <<< 1) - (diag <<< 1) + vf + ((cc <<< 3) + (cc <<< 1));
        vt   = (vn <<< 3) - (vf <<< 1) - (diag <<< 1) + hf + ((cc <<< 3) + (cc <<< 1));

        case ({head.ctrl.row_odd, head.ctrl.col_odd})
            2'b00: begin
                r_v = cc_u;
                g_v = finish(gf);
                b_v = finish(df);
            end
            2'b01: begin
                r_v = finish(hz);
                g_v = cc_u;
                b_v = finish(vt);
            end
            2'b10: begin
                r_v = finish(vt);
                g_v = cc_u;
                b_v = finish(hz);
            end
            default: begin
                r_v = finish(df);
                g_v = finish(gf);
                b_v = cc_u;
            end
        endcase
        m_tdata_next = {b_v, g_v, r_v};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pop && head.ctrl.do_win) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head.ctrl.do_edge) begin
            edge_reg[head.ctrl.edge_slot] <= head.column;
        end
        if (pop && head.ctrl.do_win) begin
            for (int i = 0; i < 5; i++) begin
                win_reg[i] <= win_next[i];
            end
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= head.ctrl.frame_end;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dmsc_checker.sv =====
// port-level checks for the demosaic top level, bound to it below
// depends on dmsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dmsc_checker import dmsc_pkg::*; (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic [PIX_W-1:0]    s_tdata,
    input wire logic                s_tuser,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [3*PIX_W-1:0]  m_tdata,
    input wire logic                m_tlast,
    input wire logic                psel,
    input wire logic                penable,
    input wire logic                pwrite,
    input wire logic [2:0]          paddr,
    input wire logic [31:0]         pwdata,
    input wire logic [31:0]         prdata,
    input wire logic                pready
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed under stall");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_prdata_upper: assert property (@(posedge aclk) disable iff (!aresetn)
        prdata[31:DIM_W] == '0)
        else $error("register readback upper bits set");

    a_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready) ##1 (paddr[2] == $past(paddr[2]))
        |-> prdata[DIM_W-1:0] == $past(pwdata[DIM_W-1:0]))
        else $error("register readback mismatch");

endmodule

bind bayer_demosaic_mhc_5x5 dmsc_checker u_dmsc_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
// self-checking testbench for bayer_demosaic_mhc_5x5: queue-fed stream driver,
// clocked monitor with a bit-exact demosaic predictor, apb register writes
// depends on hdl/dmsc_pkg.sv and hdl/bayer_demosaic_mhc_5x5.sv
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import dmsc_pkg::*;

    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;
    localparam logic       KIND_PIXEL  = 1'b0;
    localparam logic       KIND_DRAIN  = 1'b1;
    localparam int         STALL_LIMIT = 4000;
    localparam int         HOLD_CYCLES = 400;

    typedef struct {
        logic             kind;
        logic [PIX_W-1:0] pix;
    } raw_beat_t;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } rgb_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [3*PIX_W-1:0]   m_tdata;
    logic                 m_tlast;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    bayer_demosaic_mhc_5x5 dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    raw_beat_t pending_beats[$];
    rgb_t      expected_rgb[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        pressure_on = 1'b0;
    int        errors = 0;
    int        beats_in = 0;
    int        beats_out = 0;
    int        frames_done = 0;

    // predictor state
    logic [DIM_W-1:0] cfg_width = WIDTH_RESET;
    logic [DIM_W-1:0] cfg_height = HEIGHT_RESET;
    bit [PIX_W-1:0]   line_mem[4*MAX_WIDTH];
    bit [PIX_W-1:0]   win[25];
    bit [PIX_W-1:0]   edge_cols[10];
    int               in_col = 0, in_row = 0, out_col = 0, out_row = 0;

    function automatic int eff_w(int w);
        return w < 4 ? 4 : (w > MAX_WIDTH ? MAX_WIDTH : w);
    endfunction

    function automatic int eff_h(int h);
        return h < 4 ? 4 : h;
    endfunction

    function automatic int fold_row(int y, int h);
        if (y < 0) y += 2;
        if (y >= h) y -= 2;
        if (y < 0) y = 0;
        return y;
    endfunction

    function automatic column_t fetch_column(int rc, int col, bit live, bit [7:0] pix, int h);
        column_t c;
        int y;
        for (int k = 0; k < 5; k++) begin
            y = fold_row(rc - 2 + k, h);
            if (live && y == in_row) c[k] = pix;
            else c[k] = line_mem[(y & 3) * MAX_WIDTH + (col % MAX_WIDTH)];
        end
        return c;
    endfunction

    function automatic int tap(int dy, int dx);
        return int'(win[(dx + 2) * 5 + dy + 2]);
    endfunction

    function automatic bit [7:0] sat16(int s);
        if (s < 0) return 8'd0;
        s = s >>> 4;
        return s > 255 ? 8'd255 : s[7:0];
    endfunction

    function automatic bit demosaic_step(logic kind, logic [7:0] pix, output rgb_t o);
        int w, h, vr, vc, r, c;
        int cc, hn, vn, hf, vf, diag, gf, df, hz, vt;
        bit live, started;
        column_t col;
        w = eff_w(cfg_width);
        h = eff_h(cfg_height);
        live = in_row < h;
        o = '{default: '0};
        if (live && kind == KIND_DRAIN) return 1'b0;
        if (!live && out_row >= h) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            return 1'b0;
        end
        if (live) begin
            vr = in_row; vc = in_col;
            started = vr > 2 || (vr == 2 && vc >= 2);
        end else begin
            started = 1'b1;
            if (out_col + 3 <= w) begin
                vr = out_row + 2; vc = out_col + 2;
            end else begin
                vr = out_row + 3; vc = out_col - (w - 2);
            end
        end
        if (vc < 2 && vr >= 2 && vr - 2 < h) begin
            col = fetch_column(vr - 2, vc, live, pix, h);
            for (int k = 0; k < 5; k++) edge_cols[vc * 5 + k] = col[k];
        end
        if (started) begin
            r = out_row;
            c = out_col;
            if (c == 0) begin
                for (int i = 0; i < 10; i++) begin
                    win[i] = edge_cols[i];
                    win[i + 10] = edge_cols[i];
                end
                col = fetch_column(r, 2, live, pix, h);
                for (int k = 0; k < 5; k++) win[20 + k] = col[k];
            end else begin
                for (int i = 0; i < 20; i++) win[i] = win[i + 5];
                if (c + 3 <= w) begin
                    col = fetch_column(r, c + 2, live, pix, h);
                    for (int k = 0; k < 5; k++) win[20 + k] = col[k];
                end else begin
                    for (int k = 0; k < 5; k++) win[20 + k] = win[10 + k];
                end
            end
            cc = tap(0, 0);
            hn = tap(0, -1) + tap(0, 1);
            vn = tap(-1, 0) + tap(1, 0);
            hf = tap(0, -2) + tap(0, 2);
            vf = tap(-2, 0) + tap(2, 0);
            diag = tap(-1, -1) + tap(-1, 1) + tap(1, -1) + tap(1, 1);
            gf = 4 * (hn + vn) - 2 * (hf + vf) + 8 * cc;
            df = 4 * diag - 3 * (hf + vf) + 12 * cc;
            hz = 8 * hn - 2 * hf - 2 * diag + vf + 10 * cc;
            vt = 8 * vn - 2 * vf - 2 * diag + hf + 10 * cc;
            if ((r & 1) == 0) begin
                if ((c & 1) == 0) begin
                    o.red = cc[7:0]; o.green = sat16(gf); o.blue = sat16(df);
                end else begin
                    o.red = sat16(hz); o.green = cc[7:0]; o.blue = sat16(vt);
                end
            end else begin
                if ((c & 1) == 0) begin
                    o.red = sat16(vt); o.green = cc[7:0]; o.blue = sat16(hz);
                end else begin
                    o.red = sat16(df); o.green = sat16(gf); o.blue = cc[7:0];
                end
            end
            o.last = (r == h - 1 && c == w - 1);
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
            if (o.last) begin
                in_col = 0; in_row = 0; out_col = 0; out_row = 0;
                return 1'b1;
            end
        end
        if (live) begin
            line_mem[(in_row & 3) * MAX_WIDTH + (in_col % MAX_WIDTH)] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        return started;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge aclk) begin
        raw_beat_t b;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                b = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= b.pix;
                s_tuser  <= b.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off while the sender keeps going
    int  hold_left = 0;
    bit  hold_used = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (pressure_on && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    // monitor
    always @(posedge aclk) begin
        rgb_t want, got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                beats_in++;
                if (demosaic_step(s_tuser, s_tdata, want)) expected_rgb.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                beats_out++;
                got.red = m_tdata[7:0];
                got.green = m_tdata[15:8];
                got.blue = m_tdata[23:16];
                got.last = m_tlast;
                if (expected_rgb.size() == 0) begin
                    $display("[%0t] result beat with nothing expected", $time);
                    errors++;
                end else begin
                    want = expected_rgb.pop_front();
                    if (got.red != want.red) report_mismatch("red", got.red, want.red);
                    if (got.green != want.green) report_mismatch("green", got.green, want.green);
                    if (got.blue != want.blue) report_mismatch("blue", got.blue, want.blue);
                    if (got.last != want.last) report_mismatch("tlast", got.last, want.last);
                    if (got.last) frames_done++;
                end
            end
        end
    end

    // watchdog
    int quiet = 0;
    always @(posedge aclk) begin
        if ((pending_beats.size() > 0 || s_tvalid || expected_rgb.size() > 0) &&
            !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
            quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end else begin
            quiet <= 0;
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_WIDTH) cfg_width = value[DIM_W-1:0];
        else cfg_height = value[DIM_W-1:0];
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_beats.size() > 0 || s_tvalid || expected_rgb.size() > 0);
        repeat (10) @(posedge aclk);
    endtask

    // one frame: raw pixels with stray early drains, a flush tail that mixes
    // pixel and drain kinds, then a few drains while idle
    task automatic run_frame(int wreg, int hreg, bit extremes, int stray_pct);
        int w, h;
        raw_beat_t b;
        apb_write(ADDR_WIDTH, wreg);
        apb_write(ADDR_HEIGHT, hreg);
        w = eff_w(wreg);
        h = eff_h(hreg);
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(99) < stray_pct) begin
                b.kind = KIND_DRAIN; b.pix = 8'($urandom);
                pending_beats.push_back(b);
            end
            b.kind = KIND_PIXEL;
            b.pix = extremes ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
            pending_beats.push_back(b);
        end
        for (int i = 0; i < 2 * w + 2; i++) begin
            b.kind = $urandom_range(99) < 20 ? KIND_PIXEL : KIND_DRAIN;
            b.pix = 8'($urandom);
            pending_beats.push_back(b);
        end
        for (int i = $urandom_range(2); i > 0; i--) begin
            b.kind = KIND_DRAIN; b.pix = 8'($urandom);
            pending_beats.push_back(b);
        end
        wait_drained();
    endtask

    initial begin
        int budget;
        raw_beat_t b;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: early drain, saturating extremes, undersized registers
        b.kind = KIND_DRAIN; b.pix = 8'hA5;
        pending_beats.push_back(b);
        run_frame(4, 4, 1'b1, 0);
        run_frame(0, 3, 1'b0, 10);
        run_frame(13, 5, 1'b1, 0);
        run_frame(3, 6, 1'b0, 0);
        run_frame(5, 4, 1'b0, 0);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 66 : (phase == 3 ? 38 : 0);
            recv_stall_pct = (phase == 2) ? 66 : (phase == 3 ? 38 : 0);
            budget = 400;
            while (budget > 0) begin
                if (phase == 2 && !pressure_on) pressure_on = 1'b1;
                if ($urandom_range(9) == 0)
                    run_frame($urandom_range(3), $urandom_range(3), $urandom_range(3) == 0, 5);
                else
                    run_frame($urandom_range(4, 12), $urandom_range(4, 8),
                              $urandom_range(3) == 0, 5);
                budget -= eff_w(cfg_width) * eff_h(cfg_height) + 2 * eff_w(cfg_width);
            end
        end

        wait_drained();
        $display("run covered %0d input beats and %0d result beats over %0d frames,",
                 beats_in, beats_out, frames_done);
        $display("sizes from the clamped minimum up to 13 wide and 8 tall, four idling modes");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
